// ===== rtl/rrs_pkg.sv =====
// ----------------------------------------------------------------------------
// rrs_pkg: region RGB sum of squared differences, shared definitions
// Types, sizes and register indexes of the region SSD block.
// ----------------------------------------------------------------------------
`default_nettype none

package rrs_pkg;

	localparam int MAX_DIM  = 4096;
	localparam int ACC_BITS = 48;

	localparam int CNT_W   = $clog2(MAX_DIM);
	localparam int PIX_W   = 8;
	localparam int SQ_W    = 2 * PIX_W;
	localparam int ADD_W   = SQ_W + 2;
	localparam int TOTAL_W = 48;

	localparam int DIM_CFG_W = 13;
	localparam int POS_CFG_W = 12;
	localparam int CFG_W     = 13;
	localparam int IDX_W     = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_FRAME_WIDTH  = 3'd0,
		REG_FRAME_HEIGHT = 3'd1,
		REG_REGION_LEFT  = 3'd2,
		REG_REGION_TOP   = 3'd3,
		REG_REGION_COLS  = 3'd4,
		REG_REGION_ROWS  = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic [PIX_W-1:0] red_a;
		logic [PIX_W-1:0] green_a;
		logic [PIX_W-1:0] blue_a;
		logic [PIX_W-1:0] red_b;
		logic [PIX_W-1:0] green_b;
		logic [PIX_W-1:0] blue_b;
	} pixel_pair_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] total_error;
		logic               saturated;
	} ssd_result_t;

endpackage

`default_nettype wire

// ===== rtl/region_rgb_ssd_top.sv =====
// ----------------------------------------------------------------------------
// region_rgb_ssd_top: sum of squared RGB differences over a rectangle
// Accumulates squared channel differences of co-located pixel pairs that
// fall inside a clipped rectangle and reports the total once per frame.
// ----------------------------------------------------------------------------
//  channel | signals                      | transfer when
//  --------+------------------------------+------------------------------
//  in      | in_valid, in_stall, in_data   | in_valid & !in_stall
//  out     | out_valid, out_stall, out_data| out_valid & !out_stall
//  cfg     | cfg_we, cfg_index, cfg_data   | cfg_we
//
//  One pixel pair per cycle unless in_stall; the frame's last pixel
//  passes diff stage, square-sum stage and result register to out_data.
//  Reset clears counters, accumulator, valids; config returns to defaults.
//  in_stall rises only when a frame's last pixel reaches the accumulator
//  while the previous result is still held by out_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module region_rgb_ssd_top
	import rrs_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [IDX_W-1:0]     cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire pixel_pair_t          in_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output ssd_result_t               out_data
);

	localparam int CMP_W = (CNT_W > DIM_CFG_W) ? CNT_W + 2 : DIM_CFG_W + 2;
	localparam logic [ACC_BITS-1:0] ACC_MAX = '1;

	logic [DIM_CFG_W-1:0] frame_width_q, frame_height_q;
	logic [POS_CFG_W-1:0] region_left_q, region_top_q;
	logic [DIM_CFG_W-1:0] region_cols_q, region_rows_q;

	logic [CNT_W-1:0]    col_q, row_q;
	logic [ACC_BITS-1:0] acc_q;
	logic                clip_q;
	logic                out_valid_q;
	ssd_result_t         out_data_q;

	logic             s1_valid, s1_region, s1_last;
	logic [PIX_W-1:0] s1_dr, s1_dg, s1_db;
	logic             s2_valid, s2_region, s2_last;
	logic [ADD_W-1:0] s2_add;

	logic             accept, hold, adv;
	logic [CNT_W-1:0] last_col, last_row;
	logic             col_end, row_end, in_cols, in_rows;
	logic [CMP_W-1:0] col_x, row_x, left_x, top_x, right_x, bottom_x;
	logic [ACC_BITS:0] acc_sum;
	logic [ACC_BITS-1:0] acc_new;
	logic             clip_new;

	function automatic logic [CNT_W-1:0] last_index(input logic [DIM_CFG_W-1:0] dim);
		int v;
		v = int'(dim);
		if (v == 0)
			v = 1;
		else if (v > MAX_DIM)
			v = MAX_DIM;
		return CNT_W'(v - 1);
	endfunction

	function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	assign hold   = s2_valid && s2_last && out_valid_q && out_stall;
	assign adv    = !hold;
	assign accept = in_valid && !hold;
	assign in_stall = hold;

	assign last_col = last_index(frame_width_q);
	assign last_row = last_index(frame_height_q);
	assign col_end  = col_q >= last_col;
	assign row_end  = row_q >= last_row;

	assign col_x    = CMP_W'(col_q);
	assign row_x    = CMP_W'(row_q);
	assign left_x   = CMP_W'(region_left_q);
	assign top_x    = CMP_W'(region_top_q);
	assign right_x  = CMP_W'(region_left_q) + CMP_W'(region_cols_q);
	assign bottom_x = CMP_W'(region_top_q) + CMP_W'(region_rows_q);
	assign in_cols  = (col_x >= left_x) && (col_x < right_x);
	assign in_rows  = (row_x >= top_x) && (row_x < bottom_x);

	// saturating accumulate; flag stays set until the frame ends
	assign acc_sum  = {1'b0, acc_q} + (ACC_BITS + 1)'(s2_region ? s2_add : '0);
	assign acc_new  = acc_sum[ACC_BITS] ? ACC_MAX : acc_sum[ACC_BITS-1:0];
	assign clip_new = clip_q | acc_sum[ACC_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= DIM_CFG_W'(1);
			frame_height_q <= DIM_CFG_W'(1);
			region_left_q  <= '0;
			region_top_q   <= '0;
			region_cols_q  <= '0;
			region_rows_q  <= '0;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[DIM_CFG_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[DIM_CFG_W-1:0];
				REG_REGION_LEFT:  region_left_q  <= cfg_data[POS_CFG_W-1:0];
				REG_REGION_TOP:   region_top_q   <= cfg_data[POS_CFG_W-1:0];
				REG_REGION_COLS:  region_cols_q  <= cfg_data[DIM_CFG_W-1:0];
				REG_REGION_ROWS:  region_rows_q  <= cfg_data[DIM_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			s1_valid    <= 1'b0;
			s2_valid    <= 1'b0;
			acc_q       <= '0;
			clip_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (col_end) begin
					col_q <= '0;
					row_q <= row_end ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			if (adv) begin
				s1_valid <= accept;
				s2_valid <= s1_valid;
				if (s2_valid) begin
					if (s2_last) begin
						acc_q       <= '0;
						clip_q      <= 1'b0;
						out_valid_q <= 1'b1;
					end else begin
						acc_q  <= acc_new;
						clip_q <= clip_new;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s1_dr     <= abs_diff(in_data.red_a, in_data.red_b);
			s1_dg     <= abs_diff(in_data.green_a, in_data.green_b);
			s1_db     <= abs_diff(in_data.blue_a, in_data.blue_b);
			s1_region <= in_cols && in_rows;
			s1_last   <= col_end && row_end;
			s2_add    <= ADD_W'(s1_dr * s1_dr) + ADD_W'(s1_dg * s1_dg)
				+ ADD_W'(s1_db * s1_db);
			s2_region <= s1_region;
			s2_last   <= s1_last;
			if (s2_valid && s2_last) begin
				out_data_q.total_error <= TOTAL_W'(acc_new);
				out_data_q.saturated   <= clip_new;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(s2_valid && s2_last))
		else $error("result appeared without a frame end");

	a_clip_pins_max: assert property (@(posedge clk) disable iff (!arst_n)
		clip_q |-> acc_q == ACC_MAX)
		else $error("saturation flag set below accumulator maximum");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid_q && out_stall && s2_last))
		else $error("input stalled without a blocked result");

	a_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q)
		else $error("stalled result dropped");

endmodule

`default_nettype wire

// ===== bench/rrs_checker.sv =====
// ----------------------------------------------------------------------------
// rrs_checker: frame total predictor and scoreboard for region_rgb_ssd_top
// Tracks register writes and pixel transfers, forms the expected frame totals
// in order and compares each result transfer against the oldest one.
// ----------------------------------------------------------------------------
module rrs_checker
	import rrs_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	input  wire logic             in_valid,
	input  wire logic             in_stall,
	input  wire pixel_pair_t      in_data,
	input  wire logic             out_valid,
	input  wire logic             out_stall,
	input  wire ssd_result_t      out_data,
	output int                    fail_count,
	output int                    pending,
	output int                    totals_seen
);

	localparam logic [63:0] ACC_MAX = {64{1'b1}} >> (64 - ACC_BITS);

	logic [DIM_CFG_W-1:0] frame_w_reg, frame_h_reg, span_cols, span_rows;
	logic [POS_CFG_W-1:0] origin_col, origin_row;
	int unsigned          col_pos, row_pos;
	logic [63:0]          ssd_acc;
	logic                 acc_clipped;
	ssd_result_t          frame_totals[$];

	initial begin
		fail_count  = 0;
		pending     = 0;
		totals_seen = 0;
	end

	function automatic int unsigned effective_dim(input logic [DIM_CFG_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_DIM)
			return MAX_DIM;
		return int'(v);
	endfunction

	function automatic logic [ADD_W-1:0] pair_ssd(input pixel_pair_t p);
		int dr, dg, db;
		dr = int'(p.red_a) - int'(p.red_b);
		dg = int'(p.green_a) - int'(p.green_b);
		db = int'(p.blue_a) - int'(p.blue_b);
		return ADD_W'(dr * dr + dg * dg + db * db);
	endfunction

	task automatic report_mismatch(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%s", msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		ssd_result_t      want;
		logic [ADD_W-1:0] add;
		int unsigned      fw, fh;
		logic             hit;
		if (!arst_n) begin
			frame_w_reg = 1;
			frame_h_reg = 1;
			origin_col  = 0;
			origin_row  = 0;
			span_cols   = 0;
			span_rows   = 0;
			col_pos     = 0;
			row_pos     = 0;
			ssd_acc     = 0;
			acc_clipped = 1'b0;
			frame_totals.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (frame_totals.size() == 0) begin
					report_mismatch($sformatf("unexpected frame total %0d (saturated %0b)",
						out_data.total_error, out_data.saturated));
				end else begin
					want = frame_totals.pop_front();
					totals_seen++;
					if (out_data.total_error !== want.total_error ||
						out_data.saturated !== want.saturated) begin
						report_mismatch($sformatf(
							"frame total mismatch: expected %0d sat %0b, got %0d sat %0b",
							want.total_error, want.saturated,
							out_data.total_error, out_data.saturated));
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_FRAME_WIDTH:  frame_w_reg = cfg_data[DIM_CFG_W-1:0];
					REG_FRAME_HEIGHT: frame_h_reg = cfg_data[DIM_CFG_W-1:0];
					REG_REGION_LEFT:  origin_col  = cfg_data[POS_CFG_W-1:0];
					REG_REGION_TOP:   origin_row  = cfg_data[POS_CFG_W-1:0];
					REG_REGION_COLS:  span_cols   = cfg_data[DIM_CFG_W-1:0];
					REG_REGION_ROWS:  span_rows   = cfg_data[DIM_CFG_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				fw  = effective_dim(frame_w_reg);
				fh  = effective_dim(frame_h_reg);
				hit = col_pos >= 32'(origin_col) && col_pos < 32'(origin_col) + 32'(span_cols)
					&& row_pos >= 32'(origin_row) && row_pos < 32'(origin_row) + 32'(span_rows);
				if (hit) begin
					add = pair_ssd(in_data);
					if (ssd_acc > ACC_MAX || 64'(add) > ACC_MAX - ssd_acc) begin
						ssd_acc     = ACC_MAX;
						acc_clipped = 1'b1;
					end else begin
						ssd_acc = ssd_acc + 64'(add);
					end
				end
				// counters past a shrunken frame edge count as sitting on it
				if (col_pos >= fw - 1) begin
					col_pos = 0;
					if (row_pos >= fh - 1) begin
						want.total_error = ssd_acc[TOTAL_W-1:0];
						want.saturated   = acc_clipped;
						frame_totals.push_back(want);
						row_pos     = 0;
						ssd_acc     = 0;
						acc_clipped = 1'b0;
					end else begin
						row_pos = row_pos + 1;
					end
				end else begin
					col_pos = col_pos + 1;
				end
			end
		end
		pending = frame_totals.size();
	end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for region_rgb_ssd_top
// Directed frames cover empty, clipped and outside rectangles, zero frame
// sizes, ignored register indexes and a mid-frame resize; then random
// frames, random input gaps and output stalls. rrs_checker predicts and
// compares every frame total.
// ----------------------------------------------------------------------------
module testbench;
	import rrs_pkg::*;

	localparam int RANDOM_ITEMS = 1700;
	localparam int CALM_ITEMS   = 250;
	localparam int CYCLE_LIMIT  = 400000;

	localparam logic [IDX_W-1:0] REG_SPARE_6  = 3'd6;
	localparam logic [IDX_W-1:0] REG_SPARE_7  = 3'd7;
	localparam int unsigned      CFG_ALL_ONES = (1 << CFG_W) - 1;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_we    = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data  = '0;
	logic             in_valid  = 1'b0;
	pixel_pair_t      in_data   = '0;
	logic             out_stall = 1'b0;
	logic             in_stall;
	logic             out_valid;
	ssd_result_t      out_data;

	int          fail_count, pending, totals_seen;
	bit          quiet       = 1'b1;
	int          stall_run   = 0;
	int          cycle_count = 0;
	int          items_sent  = 0;
	int          setups      = 0;
	int unsigned cur_w       = 1;
	int unsigned cur_h       = 1;

	always #6 clk = ~clk;

	region_rgb_ssd_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	rrs_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.fail_count  (fail_count),
		.pending     (pending),
		.totals_seen (totals_seen)
	);

	always @(negedge clk) begin
		if (quiet || !arst_n) begin
			out_stall <= 1'b0;
			stall_run <= 0;
		end else if (stall_run > 0) begin
			out_stall <= 1'b1;
			stall_run <= stall_run - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			stall_run <= $urandom_range(0, 2);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic write_reg(input logic [IDX_W-1:0] idx, input int unsigned value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_W'(value);
		if (idx == REG_FRAME_WIDTH)
			cur_w = value;
		if (idx == REG_FRAME_HEIGHT)
			cur_h = value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic push_pixel(input pixel_pair_t p);
		int gap;
		gap = 0;
		if (!quiet && $urandom_range(0, 4) == 0)
			gap = $urandom_range(1, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= p;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	// pipeline drained: no totals outstanding and no pixel left in flight
	task automatic settle();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	function automatic logic [PIX_W-1:0] pick_byte(input int mode);
		if (mode == 2)
			return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
		return PIX_W'($urandom_range(0, 255));
	endfunction

	function automatic pixel_pair_t random_pixel();
		pixel_pair_t p;
		int          mode;
		mode      = $urandom_range(0, 3);
		p.red_a   = pick_byte(mode);
		p.green_a = pick_byte(mode);
		p.blue_a  = pick_byte(mode);
		p.red_b   = pick_byte(mode);
		p.green_b = pick_byte(mode);
		p.blue_b  = pick_byte(mode);
		if (mode == 1) begin
			p.red_b   = p.red_a;
			p.green_b = p.green_a;
			p.blue_b  = p.blue_a;
		end
		return p;
	endfunction

	initial begin
		int unsigned w, h, area, count, random_start;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		quiet = 1'b0;

		// defaults: single-pixel frames, empty rectangle
		push_pixel(pixel_pair_t'{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00});
		push_pixel(pixel_pair_t'{8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF});
		settle();
		setups++;

		write_reg(REG_REGION_COLS, 1);
		write_reg(REG_REGION_ROWS, 1);
		push_pixel(pixel_pair_t'{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00});
		push_pixel(pixel_pair_t'{8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF});
		push_pixel(pixel_pair_t'{8'hFF, 8'h5A, 8'h11, 8'h00, 8'h5A, 8'h11});
		push_pixel(pixel_pair_t'{8'h3C, 8'h00, 8'h77, 8'h3C, 8'hFF, 8'h77});
		push_pixel(pixel_pair_t'{8'h90, 8'hC3, 8'h01, 8'h90, 8'hC3, 8'hFE});
		push_pixel(pixel_pair_t'{8'h80, 8'h7F, 8'hA5, 8'h80, 8'h7F, 8'hA5});
		settle();
		setups++;

		// writes to unlisted indexes are dropped; zero frame size acts as one
		write_reg(REG_SPARE_6, CFG_ALL_ONES);
		write_reg(REG_SPARE_7, CFG_ALL_ONES);
		write_reg(REG_FRAME_WIDTH, 0);
		write_reg(REG_FRAME_HEIGHT, 0);
		repeat (2) push_pixel(random_pixel());
		settle();
		setups++;

		// rectangle running past the frame edges
		write_reg(REG_FRAME_WIDTH, 3);
		write_reg(REG_FRAME_HEIGHT, 2);
		write_reg(REG_REGION_LEFT, 1);
		write_reg(REG_REGION_TOP, 1);
		write_reg(REG_REGION_COLS, CFG_ALL_ONES);
		write_reg(REG_REGION_ROWS, CFG_ALL_ONES);
		repeat (6) push_pixel(random_pixel());
		settle();
		setups++;

		// shrink the frame width mid-frame: the pending pixel closes the frame
		write_reg(REG_REGION_LEFT, 0);
		write_reg(REG_REGION_TOP, 0);
		repeat (4) push_pixel(random_pixel());
		settle();
		write_reg(REG_FRAME_WIDTH, 1);
		push_pixel(random_pixel());
		settle();
		setups++;

		// rectangle wholly outside the frame
		write_reg(REG_FRAME_WIDTH, 2);
		write_reg(REG_FRAME_HEIGHT, 1);
		write_reg(REG_REGION_LEFT, 2);
		repeat (2) push_pixel(random_pixel());
		settle();
		setups++;

		random_start = items_sent;
		while (items_sent - random_start < RANDOM_ITEMS) begin
			if (items_sent - random_start >= RANDOM_ITEMS - CALM_ITEMS)
				quiet = 1'b1;
			else
				quiet = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 7))
				0:       w = 0;
				1:       w = 1;
				7:       w = $urandom_range(9, 24);
				default: w = $urandom_range(2, 8);
			endcase
			case ($urandom_range(0, 5))
				0:       h = 0;
				1:       h = 1;
				default: h = $urandom_range(2, 5);
			endcase
			write_reg(REG_FRAME_WIDTH, w);
			write_reg(REG_FRAME_HEIGHT, h);
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_REGION_LEFT, $urandom_range(0, w + 1));
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_REGION_TOP, $urandom_range(0, h + 1));
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 5))
					0:       write_reg(REG_REGION_COLS, 0);
					1:       write_reg(REG_REGION_COLS, CFG_ALL_ONES);
					default: write_reg(REG_REGION_COLS, $urandom_range(1, w + 2));
				endcase
			end
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 5))
					0:       write_reg(REG_REGION_ROWS, 0);
					1:       write_reg(REG_REGION_ROWS, CFG_ALL_ONES);
					default: write_reg(REG_REGION_ROWS, $urandom_range(1, h + 2));
				endcase
			end
			area  = ((cur_w == 0) ? 1 : cur_w) * ((cur_h == 0) ? 1 : cur_h);
			count = area * $urandom_range(1, 3);
			// sometimes stop mid-frame so the next setup resizes a live frame
			if ($urandom_range(0, 2) == 0)
				count = count + $urandom_range(0, area - 1);
			repeat (count) push_pixel(random_pixel());
			settle();
			setups++;
		end

		repeat (20) @(negedge clk);
		$display("Sent %0d pixel pairs under %0d register setups, incl. clipped and resized frames.",
			items_sent, setups);
		$display("Compared %0d frame totals, %0d mismatched.", totals_seen, fail_count);
		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/rrs_pkg.sv
rtl/region_rgb_ssd_top.sv
bench/rrs_checker.sv
bench/testbench.sv
